// ===== sv/hvps_pkg.sv =====
package hvps_pkg;

    localparam int VOLT_W  = 9;
    localparam int TICK_W  = 8;
    localparam int FORCE_W = 2;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 9;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MIN_VOLTAGE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_VOLTAGE_STEP = 3'd1;
    localparam logic [IDX_W-1:0] REG_SETTLE_TICKS = 3'd2;
    localparam logic [IDX_W-1:0] REG_FAIL_TICKS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_TEST_FORCE   = 3'd4;

    // Reset values
    localparam logic [VOLT_W-1:0]  RST_MIN_VOLTAGE  = 9'd210;
    localparam logic [VOLT_W-1:0]  RST_VOLTAGE_STEP = 9'd5;
    localparam logic [TICK_W-1:0]  RST_SETTLE_TICKS = 8'd10;
    localparam logic [TICK_W-1:0]  RST_FAIL_TICKS   = 8'd25;
    localparam logic [FORCE_W-1:0] RST_TEST_FORCE   = 2'd0;

    // Test force codes
    localparam logic [FORCE_W-1:0] FORCE_NONE = 2'd0;
    localparam logic [FORCE_W-1:0] FORCE_PRE  = 2'd1;
    localparam logic [FORCE_W-1:0] FORCE_POS  = 2'd2;
    localparam logic [FORCE_W-1:0] FORCE_NEG  = 2'd3;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef struct packed {
        logic [VOLT_W-1:0]  min_voltage;
        logic [VOLT_W-1:0]  voltage_step;
        logic [TICK_W-1:0]  settle_ticks;
        logic [TICK_W-1:0]  fail_ticks;
        logic [FORCE_W-1:0] test_force;
    } t_cfg;

    typedef struct packed {
        logic pre;
        logic pos;
        logic neg;
        logic done;
        logic fail;
    } t_status;

endpackage

// ===== sv/hv_precharge_sequencer.sv =====
// Precharge and contactor sequencer, one input transfer per control tick.
// Each tick (ignition, inverter voltage) yields one result: the three
// contactor drives with the test force applied, plus done and failed flags.
// The tick is evaluated combinationally as it is accepted, and the result sits
// in an output register; a new tick is taken every cycle as long as the
// result register is empty or being drained in the same cycle, so the
// sustained rate is one tick per clock. Write configuration only when idle.
module hv_precharge_sequencer
    import hvps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_ignition_on,
    input  logic [VOLT_W-1:0] i_inverter_voltage,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_precharge_relay,
    output logic              o_positive_contactor,
    output logic              o_negative_contactor,
    output logic              o_precharge_done,
    output logic              o_precharge_failed
);

    t_cfg    cfg;
    t_status status;
    t_status forced;
    t_status r_out;
    logic    r_out_valid;
    logic    step;

    hvps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign o_ready = !r_out_valid || i_ready;
    assign step    = i_valid && o_ready;

    hvps_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_ignition_on (i_ignition_on),
        .i_voltage     (i_inverter_voltage),
        .i_cfg         (cfg),
        .o_status      (status)
    );

    // OR the test-forced contactor onto the drive
    always_comb begin
        forced = status;
        case (cfg.test_force)
            FORCE_NONE: ;
            FORCE_PRE:  forced.pre = 1'b1;
            FORCE_POS:  forced.pos = 1'b1;
            FORCE_NEG:  forced.neg = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= forced;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_precharge_relay    = r_out.pre;
    assign o_positive_contactor = r_out.pos;
    assign o_negative_contactor = r_out.neg;
    assign o_precharge_done     = r_out.done;
    assign o_precharge_failed   = r_out.fail;

endmodule

// ===== sv/hvps_cfg.sv =====
module hvps_cfg
    import hvps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_voltage  <= RST_MIN_VOLTAGE;
            r_cfg.voltage_step <= RST_VOLTAGE_STEP;
            r_cfg.settle_ticks <= RST_SETTLE_TICKS;
            r_cfg.fail_ticks   <= RST_FAIL_TICKS;
            r_cfg.test_force   <= RST_TEST_FORCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_VOLTAGE:  r_cfg.min_voltage  <= i_cfg_data[VOLT_W-1:0];
                REG_VOLTAGE_STEP: r_cfg.voltage_step <= i_cfg_data[VOLT_W-1:0];
                REG_SETTLE_TICKS: r_cfg.settle_ticks <= i_cfg_data[TICK_W-1:0];
                REG_FAIL_TICKS:   r_cfg.fail_ticks   <= i_cfg_data[TICK_W-1:0];
                REG_TEST_FORCE:   r_cfg.test_force   <= i_cfg_data[FORCE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/hvps_core.sv =====
module hvps_core
    import hvps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_ignition_on,
    input  logic [VOLT_W-1:0] i_voltage,
    input  t_cfg              i_cfg,
    output t_status           o_status
);

    logic [VOLT_W-1:0] r_tracked, n_tracked;
    logic [TICK_W-1:0] r_settle, n_settle;
    logic [TICK_W-1:0] r_pcount, n_pcount;
    logic              r_done, n_done;
    logic              r_fail, n_fail;
    logic              r_pre, n_pre;
    logic              r_pos, n_pos;
    logic              r_neg, n_neg;

    logic [VOLT_W-1:0] diff;
    logic [TICK_W-1:0] settle_base;
    logic [TICK_W-1:0] settle_inc;
    logic              moved;

    always_comb begin
        diff = (i_voltage > r_tracked) ? (i_voltage - r_tracked) : (r_tracked - i_voltage);
        moved = diff > i_cfg.voltage_step;
        settle_base = moved ? '0 : r_settle;
        settle_inc = (settle_base == TICK_MAX) ? TICK_MAX : settle_base + 1'b1;

        n_tracked = r_tracked;
        n_settle  = r_settle;
        n_pcount  = r_pcount;
        n_done    = r_done;
        n_fail    = r_fail;
        n_pre     = r_pre;
        n_pos     = r_pos;
        n_neg     = r_neg;

        if (!i_ignition_on || r_fail) begin
            n_tracked = '0;
            n_settle  = '0;
            n_pcount  = '0;
            n_done    = 1'b0;
            n_fail    = 1'b0;
            n_pre     = 1'b0;
            n_pos     = 1'b0;
            n_neg     = 1'b0;
        end else if (r_done) begin
            // hold everything once complete
        end else if (r_pcount > i_cfg.fail_ticks) begin
            n_fail = 1'b1;
        end else begin
            n_tracked = moved ? i_voltage : r_tracked;
            n_settle  = settle_inc;
            if (settle_inc <= i_cfg.settle_ticks || n_tracked < i_cfg.min_voltage) begin
                n_pre    = 1'b1;
                n_pos    = 1'b0;
                n_neg    = 1'b1;
                n_pcount = (r_pcount == TICK_MAX) ? TICK_MAX : r_pcount + 1'b1;
            end else begin
                n_pre    = 1'b0;
                n_pos    = 1'b1;
                n_neg    = 1'b1;
                n_pcount = '0;
                n_done   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked <= '0;
            r_settle  <= '0;
            r_pcount  <= '0;
            r_done    <= 1'b0;
            r_fail    <= 1'b0;
            r_pre     <= 1'b0;
            r_pos     <= 1'b0;
            r_neg     <= 1'b0;
        end else if (i_step) begin
            r_tracked <= n_tracked;
            r_settle  <= n_settle;
            r_pcount  <= n_pcount;
            r_done    <= n_done;
            r_fail    <= n_fail;
            r_pre     <= n_pre;
            r_pos     <= n_pos;
            r_neg     <= n_neg;
        end
    end

    assign o_status.pre  = n_pre;
    assign o_status.pos  = n_pos;
    assign o_status.neg  = n_neg;
    assign o_status.done = n_done;
    assign o_status.fail = n_fail;

endmodule

// ===== tb/hvps_contactor_check.sv =====
module hvps_contactor_check
    import hvps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_ignition_on,
    input  logic [VOLT_W-1:0] i_inverter_voltage,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_status           i_status,
    output int                o_errors,
    output int                o_pending,
    output int                o_results,
    output int                o_done_seen,
    output int                o_timeout_seen
);

    t_cfg              cfg;
    logic [VOLT_W-1:0] tracked_v;
    logic [TICK_W-1:0] settle_cnt;
    logic [TICK_W-1:0] precharge_cnt;
    logic              done_q;
    logic              timeout_q;
    logic              pre_drv;
    logic              pos_drv;
    logic              neg_drv;

    t_status contactor_due[$];
    int      errors;
    int      results;
    int      done_seen;
    int      timeout_seen;

    function automatic void clear_sequence();
        tracked_v     = '0;
        settle_cnt    = '0;
        precharge_cnt = '0;
        done_q        = 1'b0;
        timeout_q     = 1'b0;
        pre_drv       = 1'b0;
        pos_drv       = 1'b0;
        neg_drv       = 1'b0;
    endfunction

    // One control tick of the sequencer; returns the contactor status it leaves.
    function automatic t_status advance_sequence(input logic ign,
                                                 input logic [VOLT_W-1:0] volt);
        logic [VOLT_W-1:0] diff;
        t_status           st;
        if (!ign || timeout_q) begin
            clear_sequence();
        end else if (done_q) begin
            // hold everything once complete
        end else if (precharge_cnt > cfg.fail_ticks) begin
            timeout_q = 1'b1;
        end else begin
            diff = (volt > tracked_v) ? volt - tracked_v : tracked_v - volt;
            if (diff > cfg.voltage_step) begin
                tracked_v  = volt;
                settle_cnt = '0;
            end
            if (settle_cnt != TICK_MAX) settle_cnt = settle_cnt + 1'b1;
            if (settle_cnt <= cfg.settle_ticks || tracked_v < cfg.min_voltage) begin
                pre_drv = 1'b1;
                pos_drv = 1'b0;
                neg_drv = 1'b1;
                if (precharge_cnt != TICK_MAX) precharge_cnt = precharge_cnt + 1'b1;
            end else begin
                precharge_cnt = '0;
                done_q        = 1'b1;
                pre_drv       = 1'b0;
                pos_drv       = 1'b1;
                neg_drv       = 1'b1;
            end
        end
        // test force is ORed on in every state
        st.pre  = pre_drv | (cfg.test_force == FORCE_PRE);
        st.pos  = pos_drv | (cfg.test_force == FORCE_POS);
        st.neg  = neg_drv | (cfg.test_force == FORCE_NEG);
        st.done = done_q;
        st.fail = timeout_q;
        return st;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endtask

    always @(posedge i_clk) begin
        t_status want;
        t_status due_next;
        if (!i_rst_n) begin
            cfg.min_voltage  = RST_MIN_VOLTAGE;
            cfg.voltage_step = RST_VOLTAGE_STEP;
            cfg.settle_ticks = RST_SETTLE_TICKS;
            cfg.fail_ticks   = RST_FAIL_TICKS;
            cfg.test_force   = RST_TEST_FORCE;
            clear_sequence();
            contactor_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MIN_VOLTAGE:  cfg.min_voltage  = i_cfg_data[VOLT_W-1:0];
                    REG_VOLTAGE_STEP: cfg.voltage_step = i_cfg_data[VOLT_W-1:0];
                    REG_SETTLE_TICKS: cfg.settle_ticks = i_cfg_data[TICK_W-1:0];
                    REG_FAIL_TICKS:   cfg.fail_ticks   = i_cfg_data[TICK_W-1:0];
                    REG_TEST_FORCE:   cfg.test_force   = i_cfg_data[FORCE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                results++;
                if (i_status.done === 1'b1) done_seen++;
                if (i_status.fail === 1'b1) timeout_seen++;
                if (contactor_due.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with none due, got %05b",
                                         results, i_status));
                end else begin
                    want = contactor_due.pop_front();
                    if (want !== i_status)
                        flag_error($sformatf({"result %0d (pre,pos,neg,done,timeout): ",
                                              "want %05b got %05b"},
                                             results, want, i_status));
                end
            end
            if (i_in_valid && i_in_ready) begin
                due_next      = advance_sequence(i_ignition_on, i_inverter_voltage);
                contactor_due = {contactor_due, due_next};
            end
        end
        o_pending      <= contactor_due.size();
        o_errors       <= errors;
        o_results      <= results;
        o_done_seen    <= done_seen;
        o_timeout_seen <= timeout_seen;
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import hvps_pkg::*;

    localparam int N_ITEMS         = 1650;
    localparam int N_SETUPS        = 12;
    localparam int HOLD_OFF_CYCLES = 80;

    // indexes past the register map; writes there must be ignored
    localparam logic [IDX_W-1:0]   REG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0]   REG_SPARE_HI = 3'd7;
    localparam logic [FORCE_W-1:0] FORCE_ORDER [4] = '{FORCE_NONE, FORCE_PRE,
                                                       FORCE_POS, FORCE_NEG};

    logic              i_clk              = 1'b0;
    logic              i_rst_n            = 1'b0;
    logic              i_cfg_we           = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx          = '0;
    logic [DATA_W-1:0] i_cfg_data         = '0;
    logic              i_valid            = 1'b0;
    logic              i_ignition_on      = 1'b0;
    logic [VOLT_W-1:0] i_inverter_voltage = '0;
    logic              i_ready            = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_precharge_relay;
    logic              o_positive_contactor;
    logic              o_negative_contactor;
    logic              o_precharge_done;
    logic              o_precharge_failed;

    int                errors;
    int                pending;
    int                results;
    int                done_seen;
    int                timeout_seen;
    int                ticks_sent   = 0;
    bit                steady       = 1'b0;
    bit                hold_request = 1'b0;
    logic [VOLT_W-1:0] step_now     = RST_VOLTAGE_STEP;

    always #5 i_clk = ~i_clk;

    hv_precharge_sequencer dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_ignition_on        (i_ignition_on),
        .i_inverter_voltage   (i_inverter_voltage),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_precharge_relay    (o_precharge_relay),
        .o_positive_contactor (o_positive_contactor),
        .o_negative_contactor (o_negative_contactor),
        .o_precharge_done     (o_precharge_done),
        .o_precharge_failed   (o_precharge_failed)
    );

    hvps_contactor_check contactor_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_valid),
        .i_in_ready         (o_ready),
        .i_ignition_on      (i_ignition_on),
        .i_inverter_voltage (i_inverter_voltage),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_status           ({o_precharge_relay, o_positive_contactor, o_negative_contactor,
                              o_precharge_done, o_precharge_failed}),
        .o_errors           (errors),
        .o_pending          (pending),
        .o_results          (results),
        .o_done_seen        (done_seen),
        .o_timeout_seen     (timeout_seen)
    );

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Returns at the edge where the tick transfers; valid stays up for the next one.
    task automatic send_tick(input logic ign, input logic [VOLT_W-1:0] volt);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        // drop any write strobe left from setup
        i_cfg_we <= 1'b0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_ignition_on      <= ign;
        i_inverter_voltage <= volt;
        do @(posedge i_clk); while (!o_ready);
        ticks_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic program_setup(input int p);
        logic [VOLT_W-1:0]  min_v;
        logic [VOLT_W-1:0]  step_v;
        logic [TICK_W-1:0]  settle;
        logic [TICK_W-1:0]  limit;
        logic [FORCE_W-1:0] force_code;
        min_v      = (p == 1) ? '0 : (p == 2) ? '1 : VOLT_W'($urandom_range(0, 400));
        step_v     = (p == 3) ? '0 : (p == 4) ? '1 : VOLT_W'($urandom_range(0, 24));
        settle     = (p == 5) ? '0 : (p == 6) ? '1 : TICK_W'($urandom_range(0, 16));
        limit      = (p == 7) ? '0 : (p == 8) ? '1 : TICK_W'($urandom_range(0, 40));
        force_code = FORCE_ORDER[p % 4];
        write_reg(REG_MIN_VOLTAGE, min_v);
        write_reg(REG_VOLTAGE_STEP, step_v);
        // junk in the upper data bits must be masked off
        write_reg(REG_SETTLE_TICKS, {1'($urandom_range(0, 1)), settle});
        write_reg(REG_FAIL_TICKS, {1'($urandom_range(0, 1)), limit});
        write_reg(REG_TEST_FORCE, {7'($urandom_range(0, 127)), force_code});
        step_now = step_v;
    endtask

    // A voltage ramp toward a random level, then jitter mostly within the step,
    // with occasional ignition drops and wild readings.
    task automatic run_session(input int len);
        int   target;
        int   level;
        int   wobble;
        int   volt;
        logic ign;
        target = $urandom_range(0, 511);
        level  = $urandom_range(0, 30);
        for (int k = 0; k < len; k++) begin
            ign = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) != 0);
            level = level + (target - level) / 3;
            if (target - level < 3 && level - target < 3) level = target;
            wobble = ($urandom_range(0, 9) == 0) ? int'(step_now) + 1
                                                 : $urandom_range(0, int'(step_now));
            volt = $urandom_range(0, 1) ? level + wobble : level - wobble;
            if (volt < 0) volt = 0;
            if (volt > 511) volt = 511;
            if ($urandom_range(0, 11) == 0) volt = $urandom_range(0, 511);
            send_tick(ign, VOLT_W'(volt));
        end
    endtask

    initial begin : drain
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : stimulus
        int quota;
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: ignition off, then a steady 300 V settles and closes
        send_tick(1'b0, 9'd511);
        repeat (12) send_tick(1'b1, 9'd300);
        send_tick(1'b1, 9'd511);
        send_tick(1'b0, 9'd0);

        // immediate timeout, settle never reached, precharge forced
        wait_idle();
        write_reg(REG_FAIL_TICKS, 9'd0);
        write_reg(REG_SETTLE_TICKS, 9'h1FF);
        write_reg(REG_TEST_FORCE, {7'd0, FORCE_PRE});
        send_tick(1'b1, 9'd0);
        send_tick(1'b1, 9'd0);
        send_tick(1'b1, 9'd100);
        send_tick(1'b1, 9'd511);
        send_tick(1'b1, 9'd200);

        // no settle time at all, zero and full-scale minimum
        wait_idle();
        write_reg(REG_TEST_FORCE, {7'd0, FORCE_POS});
        write_reg(REG_SPARE_LO, 9'h1AA);
        write_reg(REG_SETTLE_TICKS, 9'd0);
        write_reg(REG_FAIL_TICKS, 9'h0FF);
        write_reg(REG_MIN_VOLTAGE, 9'd0);
        send_tick(1'b1, 9'd511);
        send_tick(1'b0, 9'd255);
        wait_idle();
        write_reg(REG_TEST_FORCE, {7'd0, FORCE_NEG});
        write_reg(REG_SPARE_HI, 9'h155);
        write_reg(REG_MIN_VOLTAGE, 9'd511);
        send_tick(1'b1, 9'd511);
        send_tick(1'b1, 9'd510);

        for (int p = 0; p < N_SETUPS; p++) begin
            wait_idle();
            program_setup(p);
            steady = (p % 5 == 4);
            // stall the result side for a long stretch so the input backs up
            if (p == 3 || p == 9) hold_request = 1'b1;
            quota = ticks_sent + N_ITEMS / N_SETUPS;
            while (ticks_sent < quota) begin
                len = $urandom_range(4, 48);
                if (len > quota - ticks_sent) len = quota - ticks_sent;
                run_session(len);
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        $display("Covered %0d ticks over %0d random setups plus directed cases;", ticks_sent,
                 N_SETUPS);
        $display("%0d results checked, %0d with precharge done, %0d with a timeout.",
                 results, done_seen, timeout_seen);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/hvps_pkg.sv
sv/hvps_cfg.sv
sv/hvps_core.sv
sv/hv_precharge_sequencer.sv
tb/hvps_contactor_check.sv
tb/tb_top.sv
